>>> rtl/gpb_pkg.sv
// shared types and constants of the grid point binning block
`default_nettype none

package gpb_pkg;

  localparam int MAX_BINS     = 16;
  localparam int BIN_CAPACITY = 64;
  localparam int ORDINAL_BITS = 16;

  localparam int COORD_W  = 16;
  localparam int BCFG_W   = 5;
  localparam int IDX_W    = $clog2(MAX_BINS);
  localparam int BIN_W    = 2 * IDX_W;
  localparam int NBINS    = MAX_BINS * MAX_BINS;
  localparam int SLOT_W   = $clog2(BIN_CAPACITY);
  localparam int FILL_W   = SLOT_W + 1;
  localparam int ENT_AW   = BIN_W + SLOT_W;
  localparam int ENT_DEPTH = NBINS * BIN_CAPACITY;
  localparam int DIV_W    = COORD_W + 1;
  localparam int NUM_W    = DIV_W + IDX_W;
  localparam int STEP_W   = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BINS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 2'd2;

  localparam logic [BCFG_W-1:0]  RST_BINS = 5'd16;
  localparam logic [COORD_W-1:0] RST_MAX  = 16'd1023;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_PLACE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_LOOKUP,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_OUTSIDE,
    RES_RANGE,
    RES_PLACE,
    RES_QUERY
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     clear;
    logic     take_ord;
    logic     load_res;
    res_sel_t res_sel;
    logic     mul;
    logic     div;
    logic     store;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic outside;
    logic range_bad;
    logic div_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic                    success;
    logic                    overflow;
    logic [IDX_W-1:0]        col;
    logic [IDX_W-1:0]        row;
    logic [FILL_W-1:0]       fill;
    logic [ORDINAL_BITS-1:0] ord;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/gpb_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module gpb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/gpb_ctrl.sv
// sequencing state machine of the grid point binning block
`default_nettype none

module gpb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gpb_pkg::dp_stat_t stat,
  output gpb_pkg::dp_cmd_t       dcmd
);

  gpb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dcmd       = '0;
    in_ready   = 1'b0;
    unique case (state)
      gpb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dcmd.capture = 1'b1;
          state_next   = gpb_pkg::ST_EVAL;
        end
      end
      gpb_pkg::ST_EVAL: begin
        unique case (stat.cmd)
          gpb_pkg::CMD_BEGIN: begin
            dcmd.clear    = 1'b1;
            dcmd.load_res = 1'b1;
            dcmd.res_sel  = gpb_pkg::RES_ZERO;
            state_next    = gpb_pkg::ST_EMIT;
          end
          gpb_pkg::CMD_PLACE: begin
            dcmd.take_ord = 1'b1;
            if (stat.outside) begin
              dcmd.load_res = 1'b1;
              dcmd.res_sel  = gpb_pkg::RES_OUTSIDE;
              state_next    = gpb_pkg::ST_EMIT;
            end else begin
              state_next = gpb_pkg::ST_MUL;
            end
          end
          gpb_pkg::CMD_QUERY: begin
            if (stat.range_bad) begin
              dcmd.load_res = 1'b1;
              dcmd.res_sel  = gpb_pkg::RES_RANGE;
              state_next    = gpb_pkg::ST_EMIT;
            end else begin
              state_next = gpb_pkg::ST_LOOKUP;
            end
          end
          default: begin
            dcmd.load_res = 1'b1;
            dcmd.res_sel  = gpb_pkg::RES_ZERO;
            state_next    = gpb_pkg::ST_EMIT;
          end
        endcase
      end
      gpb_pkg::ST_MUL: begin
        dcmd.mul   = 1'b1;
        state_next = gpb_pkg::ST_DIV;
      end
      gpb_pkg::ST_DIV: begin
        dcmd.div = 1'b1;
        if (stat.div_last) begin
          state_next = gpb_pkg::ST_LOOKUP;
        end
      end
      gpb_pkg::ST_LOOKUP: begin
        state_next = gpb_pkg::ST_DECIDE;
      end
      gpb_pkg::ST_DECIDE: begin
        dcmd.load_res = 1'b1;
        if (stat.cmd == gpb_pkg::CMD_PLACE) begin
          dcmd.res_sel = gpb_pkg::RES_PLACE;
          dcmd.store   = 1'b1;
        end else begin
          dcmd.res_sel = gpb_pkg::RES_QUERY;
        end
        state_next = gpb_pkg::ST_EMIT;
      end
      gpb_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          dcmd.emit  = 1'b1;
          state_next = gpb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gpb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/gpb_dp.sv
// datapath: config registers, bin divider, count and entry memories, output register
`default_nettype none

module gpb_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [gpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gpb_pkg::COORD_W-1:0]         cfg_data,
  input  wire logic [1:0]                          command,
  input  wire logic signed [gpb_pkg::COORD_W-1:0]  pos_x,
  input  wire logic signed [gpb_pkg::COORD_W-1:0]  pos_y,
  input  wire logic [gpb_pkg::IDX_W-1:0]           query_col,
  input  wire logic [gpb_pkg::IDX_W-1:0]           query_row,
  input  wire logic [gpb_pkg::SLOT_W-1:0]          query_slot,
  input  wire gpb_pkg::dp_cmd_t                    dcmd,
  output gpb_pkg::dp_stat_t                        stat,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output gpb_pkg::result_t                         out_res
);

  localparam int NW  = gpb_pkg::NUM_W;
  localparam int IW  = gpb_pkg::IDX_W;
  localparam int FW  = gpb_pkg::FILL_W;
  localparam int CW  = gpb_pkg::COORD_W;
  localparam int OW  = gpb_pkg::ORDINAL_BITS;

  // configuration
  logic [gpb_pkg::BCFG_W-1:0] bins_cfg;
  logic [CW-1:0]              max_x;
  logic [CW-1:0]              max_y;
  logic [gpb_pkg::BCFG_W-1:0] eff_bins;

  // captured transaction
  gpb_pkg::cmd_t              cmd_q;
  logic [CW-1:0]              px;
  logic [CW-1:0]              py;
  logic [IW-1:0]              qcol;
  logic [IW-1:0]              qrow;
  logic [gpb_pkg::SLOT_W-1:0] qslot;

  // ordinal
  logic [OW-1:0] next_ord;
  logic [OW-1:0] ord_q;

  // divider
  logic [NW-1:0]              rem_x, rem_y;
  logic [NW-1:0]              ds_x, ds_y;
  logic [NW-1:0]              prod_x, prod_y;
  logic [gpb_pkg::STEP_W-1:0] step;
  logic [IW-1:0]              col_q, row_q;

  // bin storage
  logic [gpb_pkg::NBINS-1:0]  vbit;
  logic [gpb_pkg::BIN_W-1:0]  bin;
  logic [FW-1:0]              cnt_rdata;
  logic [OW-1:0]              ent_rdata;
  logic [FW-1:0]              fill;
  logic                       full;
  logic                       wr_en;
  logic [FW-1:0]              fill_inc;

  gpb_pkg::result_t res;
  gpb_pkg::result_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_cfg <= gpb_pkg::RST_BINS;
      max_x    <= gpb_pkg::RST_MAX;
      max_y    <= gpb_pkg::RST_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gpb_pkg::REG_BINS:  bins_cfg <= cfg_data[gpb_pkg::BCFG_W-1:0];
        gpb_pkg::REG_MAX_X: max_x    <= cfg_data;
        gpb_pkg::REG_MAX_Y: max_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bins_cfg == '0) begin
      eff_bins = gpb_pkg::BCFG_W'(1);
    end else if (bins_cfg > gpb_pkg::BCFG_W'(gpb_pkg::MAX_BINS)) begin
      eff_bins = gpb_pkg::BCFG_W'(gpb_pkg::MAX_BINS);
    end else begin
      eff_bins = bins_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.capture) begin
      cmd_q <= gpb_pkg::cmd_t'(command);
      px    <= pos_x;
      py    <= pos_y;
      qcol  <= query_col;
      qrow  <= query_row;
      qslot <= query_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_ord <= '0;
    end else if (dcmd.clear) begin
      next_ord <= '0;
    end else if (dcmd.take_ord) begin
      next_ord <= next_ord + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.take_ord) begin
      ord_q <= next_ord;
    end
  end

  // b * coordinate; only in-window points get here, so the sign bit is clear
  assign prod_x = NW'(eff_bins) * NW'(px[CW-2:0]);
  assign prod_y = NW'(eff_bins) * NW'(py[CW-2:0]);

  // restoring divide, one quotient bit per cycle, quotient always below b
  always_ff @(posedge clk) begin
    if (dcmd.capture) begin
      col_q <= query_col;
      row_q <= query_row;
    end else if (dcmd.mul) begin
      rem_x <= prod_x;
      rem_y <= prod_y;
      ds_x  <= NW'({1'b0, max_x} + (CW + 1)'(1)) << (IW - 1);
      ds_y  <= NW'({1'b0, max_y} + (CW + 1)'(1)) << (IW - 1);
      step  <= '0;
    end else if (dcmd.div) begin
      if (rem_x >= ds_x) begin
        rem_x <= rem_x - ds_x;
        col_q <= {col_q[IW-2:0], 1'b1};
      end else begin
        col_q <= {col_q[IW-2:0], 1'b0};
      end
      if (rem_y >= ds_y) begin
        rem_y <= rem_y - ds_y;
        row_q <= {row_q[IW-2:0], 1'b1};
      end else begin
        row_q <= {row_q[IW-2:0], 1'b0};
      end
      ds_x <= ds_x >> 1;
      ds_y <= ds_y >> 1;
      step <= step + gpb_pkg::STEP_W'(1);
    end
  end

  assign bin      = {col_q, row_q};
  assign fill     = vbit[bin] ? cnt_rdata : '0;
  assign full     = fill >= FW'(gpb_pkg::BIN_CAPACITY);
  assign fill_inc = fill + FW'(1);
  assign wr_en    = dcmd.store && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
    end else if (dcmd.clear) begin
      vbit <= '0;
    end else if (wr_en) begin
      vbit[bin] <= 1'b1;
    end
  end

  gpb_ram #(
    .WIDTH(gpb_pkg::FILL_W),
    .DEPTH(gpb_pkg::NBINS)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(bin),
    .wdata(fill_inc),
    .raddr(bin),
    .rdata(cnt_rdata)
  );

  gpb_ram #(
    .WIDTH(gpb_pkg::ORDINAL_BITS),
    .DEPTH(gpb_pkg::ENT_DEPTH)
  ) u_ent_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr({bin, fill[gpb_pkg::SLOT_W-1:0]}),
    .wdata(ord_q),
    .raddr({bin, qslot}),
    .rdata(ent_rdata)
  );

  always_comb begin
    res_next = '0;
    unique case (dcmd.res_sel)
      gpb_pkg::RES_ZERO: begin
        res_next = '0;
      end
      gpb_pkg::RES_OUTSIDE: begin
        res_next.ord = next_ord;
      end
      gpb_pkg::RES_RANGE: begin
        res_next.col = qcol;
        res_next.row = qrow;
      end
      gpb_pkg::RES_PLACE: begin
        res_next.col = col_q;
        res_next.row = row_q;
        res_next.ord = ord_q;
        if (full) begin
          res_next.overflow = 1'b1;
          res_next.fill     = fill;
        end else begin
          res_next.success = 1'b1;
          res_next.fill    = fill_inc;
        end
      end
      gpb_pkg::RES_QUERY: begin
        res_next.col  = col_q;
        res_next.row  = row_q;
        res_next.fill = fill;
        if (FW'(qslot) < fill) begin
          res_next.success = 1'b1;
          res_next.ord     = ent_rdata;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dcmd.load_res) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.emit) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dcmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.cmd       = cmd_q;
  assign stat.outside   = px[CW-1] || py[CW-1] || (px > max_x) || (py > max_y);
  assign stat.range_bad = (gpb_pkg::BCFG_W'(qcol) >= eff_bins) ||
                          (gpb_pkg::BCFG_W'(qrow) >= eff_bins);
  assign stat.div_last  = step == gpb_pkg::STEP_W'(IW - 1);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> rtl/grid_point_binning.sv
// top level of the grid point binning block
`default_nettype none

// grid_point_binning sorts screen points into a square grid of up to 16 x 16
// bins, each holding up to 64 point ordinals. One transaction is handled at a
// time. A place in the window goes through a multiply by the bin count, a
// 4-step restoring divider that yields one column bit and one row bit per
// cycle, a lookup state for the registered read of the count and entry
// memories, an update state and the output load. A query skips the multiply
// and divide, and begin, no-op, out-of-window points and queries of a bin
// beyond the grid go straight to the output load. A result that finds the
// output register still full waits. The output register lets the next
// transaction be accepted while a result waits for out_ready. Fill counts
// live in a ram with one valid flip-flop per bin, so begin empties every bin
// at once and there is no clearing pass after reset. Configuration writes are
// taken on any cycle with cfg_write high and should be made while the block
// is idle.
module grid_point_binning (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_write,
  input  wire logic [gpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gpb_pkg::COORD_W-1:0]         cfg_data,
  // command transaction
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          command,
  input  wire logic signed [gpb_pkg::COORD_W-1:0]  pos_x,
  input  wire logic signed [gpb_pkg::COORD_W-1:0]  pos_y,
  input  wire logic [gpb_pkg::IDX_W-1:0]           query_col,
  input  wire logic [gpb_pkg::IDX_W-1:0]           query_row,
  input  wire logic [gpb_pkg::SLOT_W-1:0]          query_slot,
  // result transaction
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     success,
  output logic                                     overflow,
  output logic [gpb_pkg::IDX_W-1:0]                bin_col,
  output logic [gpb_pkg::IDX_W-1:0]                bin_row,
  output logic [gpb_pkg::FILL_W-1:0]               bin_fill,
  output logic [gpb_pkg::ORDINAL_BITS-1:0]         point_ordinal
);

  gpb_pkg::dp_cmd_t  dcmd;
  gpb_pkg::dp_stat_t stat;
  gpb_pkg::result_t  out_res;

  // controller runs capture, divide, lookup and emit as each command needs
  gpb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .dcmd    (dcmd)
  );

  // datapath holds config, ordinal counter, divider, memories and result
  gpb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .query_col (query_col),
    .query_row (query_row),
    .query_slot(query_slot),
    .dcmd      (dcmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // unpack the output register onto the result ports
  assign success       = out_res.success;
  assign overflow      = out_res.overflow;
  assign bin_col       = out_res.col;
  assign bin_row       = out_res.row;
  assign bin_fill      = out_res.fill;
  assign point_ordinal = out_res.ord;

`ifndef ASSERT_OFF
  // one transaction at a time: no acceptance in the cycle after one
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // a stored point and a dropped point are exclusive
  a_succ_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(success && overflow))
    else $error("success and overflow both set");

  // a point is dropped only when its bin is at capacity
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (bin_fill == gpb_pkg::FILL_W'(gpb_pkg::BIN_CAPACITY)))
    else $error("overflow reported on a bin that is not full");

  // a result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    dcmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over one not yet taken");
`endif

endmodule

`default_nettype wire
